@@ hdl/utf8_validating_decoder_defines.svh @@
// assertion macros for the utf8 validating decoder checker
// no dependencies; included by the checker file only
`ifndef UTF8_VALIDATING_DECODER_DEFINES_SVH
`define UTF8_VALIDATING_DECODER_DEFINES_SVH

// same-cycle implication, sampled on the rising clock edge outside reset
`define UVD_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("utf8 decoder check failed");

// next-cycle implication, sampled on the rising clock edge outside reset
`define UVD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("utf8 decoder check failed");

`endif

@@ hdl/utf8vd_pkg.sv @@
// shared types, codes and byte-range functions for the utf8 validating decoder
// no dependencies; used by utf8vd_step and utf8_validating_decoder
package utf8vd_pkg;

   localparam logic [2:0] RULE_GENERAL = 3'd0;
   localparam logic [2:0] RULE_A0_BF   = 3'd1;
   localparam logic [2:0] RULE_80_9F   = 3'd2;
   localparam logic [2:0] RULE_90_BF   = 3'd3;
   localparam logic [2:0] RULE_80_8F   = 3'd4;

   typedef struct packed {
      logic [1:0]  bytes_remaining;
      logic [2:0]  second_byte_rule;
      logic [20:0] partial_point;
      logic        error_latched;
   } state_type;

   typedef struct packed {
      logic        point_ready;
      logic [20:0] code_point;
      logic        is_space;
      logic        bad_stream;
      logic        stream_end;
   } result_type;

   localparam state_type STATE_RESET = '{
      bytes_remaining:  2'd0,
      second_byte_rule: RULE_GENERAL,
      partial_point:    21'd0,
      error_latched:    1'b0
   };

   function automatic logic cont_ok(input logic [7:0] b, input logic [2:0] rule);
      logic ok;
      case (rule)
         RULE_A0_BF: ok = (b >= 8'hA0) && (b <= 8'hBF);
         RULE_80_9F: ok = (b >= 8'h80) && (b <= 8'h9F);
         RULE_90_BF: ok = (b >= 8'h90) && (b <= 8'hBF);
         RULE_80_8F: ok = (b >= 8'h80) && (b <= 8'h8F);
         default:    ok = (b >= 8'h80) && (b <= 8'hBF);
      endcase
      return ok;
   endfunction

   function automatic logic space_point(input logic [20:0] cp);
      return ((cp >= 21'h00009) && (cp <= 21'h0000D)) ||
             ((cp >= 21'h0001C) && (cp <= 21'h0001F)) ||
             (cp == 21'h00020) || (cp == 21'h00085) || (cp == 21'h000A0) ||
             (cp == 21'h01680) ||
             ((cp >= 21'h02000) && (cp <= 21'h0200A)) ||
             (cp == 21'h02028) || (cp == 21'h02029) || (cp == 21'h0202F) ||
             (cp == 21'h0205F) || (cp == 21'h03000);
   endfunction

endpackage

@@ hdl/utf8vd_step.sv @@
// per-byte decode step: next stream state and the result for one byte
// depends on utf8vd_pkg
module utf8vd_step (
   input  utf8vd_pkg::state_type  cur_state,
   input  logic [7:0]             data_byte,
   input  logic                   final_byte,
   output utf8vd_pkg::state_type  next_state,
   output utf8vd_pkg::result_type result
);

   logic             ready;
   logic [20:0]      cp;
   logic [20:0]      shifted;
   utf8vd_pkg::state_type nxt;

   assign shifted = {cur_state.partial_point[14:0], data_byte[5:0]};

   always_comb begin
      ready = 1'b0;
      cp    = 21'd0;
      nxt   = cur_state;
      if (!cur_state.error_latched) begin
         if (cur_state.bytes_remaining == 2'd0) begin
            if (data_byte <= 8'h7F) begin
               ready = 1'b1;
               cp    = {13'd0, data_byte};
            end else if ((data_byte >= 8'hC2) && (data_byte <= 8'hDF)) begin
               nxt.partial_point    = {16'd0, data_byte[4:0]};
               nxt.bytes_remaining  = 2'd1;
               nxt.second_byte_rule = utf8vd_pkg::RULE_GENERAL;
            end else if ((data_byte >= 8'hE0) && (data_byte <= 8'hEF)) begin
               nxt.partial_point    = {17'd0, data_byte[3:0]};
               nxt.bytes_remaining  = 2'd2;
               if (data_byte == 8'hE0) begin
                  nxt.second_byte_rule = utf8vd_pkg::RULE_A0_BF;
               end else if (data_byte == 8'hED) begin
                  nxt.second_byte_rule = utf8vd_pkg::RULE_80_9F;
               end else begin
                  nxt.second_byte_rule = utf8vd_pkg::RULE_GENERAL;
               end
            end else if ((data_byte >= 8'hF0) && (data_byte <= 8'hF4)) begin
               nxt.partial_point    = {18'd0, data_byte[2:0]};
               nxt.bytes_remaining  = 2'd3;
               if (data_byte == 8'hF0) begin
                  nxt.second_byte_rule = utf8vd_pkg::RULE_90_BF;
               end else if (data_byte == 8'hF4) begin
                  nxt.second_byte_rule = utf8vd_pkg::RULE_80_8F;
               end else begin
                  nxt.second_byte_rule = utf8vd_pkg::RULE_GENERAL;
               end
            end else begin
               nxt = utf8vd_pkg::STATE_RESET;
               nxt.error_latched = 1'b1;
            end
         end else if (utf8vd_pkg::cont_ok(data_byte, cur_state.second_byte_rule)) begin
            nxt.second_byte_rule = utf8vd_pkg::RULE_GENERAL;
            nxt.bytes_remaining  = cur_state.bytes_remaining - 2'd1;
            if (cur_state.bytes_remaining == 2'd1) begin
               ready             = 1'b1;
               cp                = shifted;
               nxt.partial_point = 21'd0;
            end else begin
               nxt.partial_point = shifted;
            end
         end else begin
            nxt = utf8vd_pkg::STATE_RESET;
            nxt.error_latched = 1'b1;
         end
      end
      if (final_byte && (nxt.bytes_remaining != 2'd0)) begin
         nxt = utf8vd_pkg::STATE_RESET;
         nxt.error_latched = 1'b1;
      end

      result.point_ready = ready;
      result.code_point  = cp;
      result.is_space    = ready && utf8vd_pkg::space_point(cp);
      result.bad_stream  = nxt.error_latched;
      result.stream_end  = final_byte;

      next_state = final_byte ? utf8vd_pkg::STATE_RESET : nxt;
   end

endmodule

@@ hdl/utf8_validating_decoder.sv @@
// top level of the streaming strict utf8 validating decoder
// depends on utf8vd_pkg and utf8vd_step
//
// req channel: one raw byte per transfer (req_data_byte) and req_final_byte,
// which marks the last byte of a stream. rsp channel: exactly one result per
// byte, in order: rsp_point_ready with rsp_code_point and rsp_is_space when a
// byte completes a valid code point, rsp_bad_stream once any invalid or
// truncated sequence was seen in the stream, rsp_stream_end on the final byte.
// both channels use valid/stall; a transfer happens when valid is high and
// stall is low.
// each byte passes through the input register, then the result register, before
// its result can transfer on the rsp channel.
// throughput: one byte per cycle while rsp_stall is low; the stream state is
// updated by the single decode step as a byte moves into the result register.
// when rsp_stall is held, the result register holds, the input register fills
// and req_stall rises; no byte is lost or repeated.
// reset (synchronous, active high) empties both registers and returns the
// stream state to the start of a stream. a final byte does the same for the
// stream state after its result is formed.
module utf8_validating_decoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_final_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_point_ready,
   output logic [20:0] rsp_code_point,
   output logic        rsp_is_space,
   output logic        rsp_bad_stream,
   output logic        rsp_stream_end
);

   logic                   in_valid_ff, in_valid_in;
   logic [7:0]             in_byte_ff, in_byte_in;
   logic                   in_final_ff, in_final_in;
   logic                   out_valid_ff, out_valid_in;
   utf8vd_pkg::result_type out_ff, out_in;
   utf8vd_pkg::state_type  state_ff, state_in;
   utf8vd_pkg::state_type  step_state;
   utf8vd_pkg::result_type step_result;
   logic                   advance;
   logic                   req_take;

   assign advance   = !out_valid_ff || !rsp_stall;
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   utf8vd_step u_step (
      .cur_state  (state_ff),
      .data_byte  (in_byte_ff),
      .final_byte (in_final_ff),
      .next_state (step_state),
      .result     (step_result)
   );

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_byte_in   = in_byte_ff;
      in_final_in  = in_final_ff;
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      state_in     = state_ff;
      if (advance) begin
         out_valid_in = in_valid_ff;
         in_valid_in  = 1'b0;
         if (in_valid_ff) begin
            out_in   = step_result;
            state_in = step_state;
         end
      end
      if (req_take) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_data_byte;
         in_final_in = req_final_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= utf8vd_pkg::STATE_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff  <= in_byte_in;
      in_final_ff <= in_final_in;
      out_ff      <= out_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_point_ready = out_ff.point_ready;
   assign rsp_code_point  = out_ff.code_point;
   assign rsp_is_space    = out_ff.is_space;
   assign rsp_bad_stream  = out_ff.bad_stream;
   assign rsp_stream_end  = out_ff.stream_end;

endmodule

@@ hdl/utf8vd_checker.sv @@
// port-level checks for the utf8 validating decoder, bound to the top level
// depends on utf8_validating_decoder_defines.svh and utf8_validating_decoder
`include "utf8_validating_decoder_defines.svh"

module utf8vd_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_point_ready,
   input logic [20:0] rsp_code_point,
   input logic        rsp_is_space,
   input logic        rsp_bad_stream,
   input logic        rsp_stream_end
);

   logic [24:0] rsp_fields;
   logic        no_point_clean;
   logic        point_in_range;

   assign rsp_fields = {rsp_point_ready, rsp_code_point, rsp_is_space, rsp_bad_stream,
                        rsp_stream_end};
   assign no_point_clean = (rsp_code_point == 21'd0) && !rsp_is_space;
   assign point_in_range = (rsp_code_point <= 21'h10FFFF) &&
                           !((rsp_code_point >= 21'h0D800) && (rsp_code_point <= 21'h0DFFF));

   `UVD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_fields))
   `UVD_ASSERT_SAME(a_no_point, clock, reset, rsp_valid && !rsp_point_ready, no_point_clean)
   `UVD_ASSERT_SAME(a_point_clean, clock, reset, rsp_valid && rsp_point_ready, !rsp_bad_stream)
   `UVD_ASSERT_SAME(a_space_point, clock, reset, rsp_valid && rsp_is_space, rsp_point_ready)
   `UVD_ASSERT_SAME(a_scalar, clock, reset, rsp_valid && rsp_point_ready, point_in_range)

endmodule

bind utf8_validating_decoder utf8vd_checker u_checker (.*);

@@ verif/utf8vd_check_pkg.sv @@
// byte-level predictor and result scoreboard for the utf8 validating decoder
// depends on utf8vd_pkg for the state, result and rule types
package utf8vd_check_pkg;
   import utf8vd_pkg::*;

   class decode_scoreboard;
      state_type   stream_state;
      result_type  expected_results[$];
      int unsigned mismatches;
      int unsigned noted_bytes;
      int unsigned checked;

      function new();
         stream_state = STATE_RESET;
         mismatches   = 0;
         noted_bytes  = 0;
         checked      = 0;
      endfunction

      function bit continuation_fits(logic [7:0] b, logic [2:0] rule);
         case (rule)
            RULE_A0_BF: return b inside {[8'hA0:8'hBF]};
            RULE_80_9F: return b inside {[8'h80:8'h9F]};
            RULE_90_BF: return b inside {[8'h90:8'hBF]};
            RULE_80_8F: return b inside {[8'h80:8'h8F]};
            default:    return b inside {[8'h80:8'hBF]};
         endcase
      endfunction

      function bit is_blank_point(logic [20:0] cp);
         return cp inside {[21'h00009:21'h0000D], [21'h0001C:21'h0001F], 21'h00020,
                           21'h00085, 21'h000A0, 21'h01680, [21'h02000:21'h0200A],
                           21'h02028, 21'h02029, 21'h0202F, 21'h0205F, 21'h03000};
      endfunction

      function void latch_error();
         stream_state = STATE_RESET;
         stream_state.error_latched = 1'b1;
      endfunction

      // accepted input transfer: work out its result and queue it
      function void note_byte(logic [7:0] b, logic fin);
         result_type want;
         want = '0;
         noted_bytes++;
         if (!stream_state.error_latched) begin
            if (stream_state.bytes_remaining == 2'd0) begin
               if (b <= 8'h7F) begin
                  want.point_ready = 1'b1;
                  want.code_point  = {13'd0, b};
               end else if (b inside {[8'hC2:8'hDF]}) begin
                  stream_state.partial_point    = {16'd0, b[4:0]};
                  stream_state.bytes_remaining  = 2'd1;
                  stream_state.second_byte_rule = RULE_GENERAL;
               end else if (b inside {[8'hE0:8'hEF]}) begin
                  stream_state.partial_point    = {17'd0, b[3:0]};
                  stream_state.bytes_remaining  = 2'd2;
                  stream_state.second_byte_rule = (b == 8'hE0) ? RULE_A0_BF :
                                                  (b == 8'hED) ? RULE_80_9F : RULE_GENERAL;
               end else if (b inside {[8'hF0:8'hF4]}) begin
                  stream_state.partial_point    = {18'd0, b[2:0]};
                  stream_state.bytes_remaining  = 2'd3;
                  stream_state.second_byte_rule = (b == 8'hF0) ? RULE_90_BF :
                                                  (b == 8'hF4) ? RULE_80_8F : RULE_GENERAL;
               end else begin
                  latch_error();
               end
            end else if (continuation_fits(b, stream_state.second_byte_rule)) begin
               stream_state.partial_point    = {stream_state.partial_point[14:0], b[5:0]};
               stream_state.second_byte_rule = RULE_GENERAL;
               stream_state.bytes_remaining  = stream_state.bytes_remaining - 2'd1;
               if (stream_state.bytes_remaining == 2'd0) begin
                  want.point_ready           = 1'b1;
                  want.code_point            = stream_state.partial_point;
                  stream_state.partial_point = '0;
               end
            end else begin
               latch_error();
            end
         end
         // truncated sequence at the end of the stream
         if (fin && stream_state.bytes_remaining != 2'd0) latch_error();
         want.is_space   = want.point_ready && is_blank_point(want.code_point);
         want.bad_stream = stream_state.error_latched;
         want.stream_end = fin;
         if (fin) stream_state = STATE_RESET;
         expected_results = {expected_results, want};
      endfunction

      task report(string what);
         $display("%0t: mismatch on result transfer %0d: %s", $time, checked, what);
         mismatches++;
      endtask

      task check_result(result_type got);
         result_type want;
         checked++;
         if (expected_results.size() == 0) begin
            report("result with nothing expected");
         end else begin
            want = expected_results.pop_front();
            if (got.point_ready !== want.point_ready)
               report($sformatf("point_ready %0b, expected %0b", got.point_ready,
                                want.point_ready));
            if (got.code_point !== want.code_point)
               report($sformatf("code_point %h, expected %h", got.code_point,
                                want.code_point));
            if (got.is_space !== want.is_space)
               report($sformatf("is_space %0b, expected %0b", got.is_space, want.is_space));
            if (got.bad_stream !== want.bad_stream)
               report($sformatf("bad_stream %0b, expected %0b", got.bad_stream,
                                want.bad_stream));
            if (got.stream_end !== want.stream_end)
               report($sformatf("stream_end %0b, expected %0b", got.stream_end,
                                want.stream_end));
         end
      endtask

      function int pending();
         return expected_results.size();
      endfunction
   endclass

endpackage

@@ verif/tb_top.sv @@
// top-level testbench for utf8_validating_decoder: byte streams, stalls, checking
// depends on utf8vd_pkg, utf8vd_check_pkg and the decoder rtl
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import utf8vd_pkg::*;
   import utf8vd_check_pkg::*;

   localparam int HALF_PERIOD  = 5;
   localparam int ITEM_GOAL    = 1450;
   localparam int STALL_LIMIT  = 1000;
   localparam int DRAIN_CYCLES = 20;

   localparam logic [20:0] EDGE_POINTS [45] = '{
      21'h9, 21'hD, 21'h1C, 21'h1F, 21'h20, 21'h85, 21'hA0, 21'h1680, 21'h2000,
      21'h200A, 21'h2028, 21'h2029, 21'h202F, 21'h205F, 21'h3000,
      21'h8, 21'hE, 21'h1B, 21'h21, 21'h84, 21'h86, 21'h9F, 21'hA1, 21'h167F,
      21'h1681, 21'h1FFF, 21'h200B, 21'h2027, 21'h202A, 21'h202E, 21'h2030,
      21'h205E, 21'h2060, 21'h2FFF, 21'h3001,
      21'h0, 21'h7F, 21'h80, 21'h7FF, 21'h800, 21'hD7FF, 21'hE000, 21'hFFFF,
      21'h10000, 21'h10FFFF
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_final_byte = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_point_ready;
   logic [20:0] rsp_code_point;
   logic        rsp_is_space;
   logic        rsp_bad_stream;
   logic        rsp_stream_end;

   result_type  seen_result;
   int          idle_cycles = 0;
   logic [7:0]  stream_q[$];

   decode_scoreboard sb = new();

   utf8_validating_decoder dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data_byte  (req_data_byte),
      .req_final_byte (req_final_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_point_ready(rsp_point_ready),
      .rsp_code_point (rsp_code_point),
      .rsp_is_space   (rsp_is_space),
      .rsp_bad_stream (rsp_bad_stream),
      .rsp_stream_end (rsp_stream_end)
   );

   always #(HALF_PERIOD) clock = ~clock;

   assign seen_result = '{point_ready: rsp_point_ready, code_point: rsp_code_point,
                          is_space: rsp_is_space, bad_stream: rsp_bad_stream,
                          stream_end: rsp_stream_end};

   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if (req_valid && !req_stall) sb.note_byte(req_data_byte, req_final_byte);
         if (rsp_valid && !rsp_stall) sb.check_result(seen_result);
         idle_cycles <= ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) ?
                        0 : idle_cycles + 1;
      end
   end

   initial begin
      wait (idle_cycles >= STALL_LIMIT);
      $display("TEST FAILED");
      $finish;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // result side back-pressure, with calm stretches
   initial begin
      int stall_len;
      int free_len;
      forever begin
         if ($urandom_range(0, 9) == 0) begin
            stall_len = 0;
            free_len  = $urandom_range(30, 150);
         end else begin
            stall_len = pick_gap();
            free_len  = $urandom_range(1, 8);
         end
         repeat (stall_len) begin
            @(negedge clock);
            rsp_stall = 1'b1;
         end
         repeat (free_len) begin
            @(negedge clock);
            rsp_stall = 1'b0;
         end
      end
   end

   function automatic void add_byte(logic [7:0] b);
      stream_q = {stream_q, b};
   endfunction

   function automatic logic [20:0] random_point();
      int r;
      logic [20:0] cp;
      r = $urandom_range(0, 99);
      if (r < 25) begin
         cp = 21'($urandom_range(0, 21'h7F));
      end else if (r < 40) begin
         cp = 21'($urandom_range(21'h80, 21'h7FF));
      end else if (r < 60) begin
         cp = 21'($urandom_range(21'h800, 21'hFFFF));
         if (cp inside {[21'hD800:21'hDFFF]}) cp = cp - 21'h1000;
      end else if (r < 75) begin
         cp = 21'($urandom_range(21'h10000, 21'h10FFFF));
      end else if (r < 80) begin
         cp = 21'h2000 + 21'($urandom_range(0, 10));
      end else begin
         cp = EDGE_POINTS[6'($urandom_range(0, 44))];
      end
      return cp;
   endfunction

   function automatic void put_point(logic [20:0] cp);
      if (cp < 21'h80) begin
         add_byte(cp[7:0]);
      end else if (cp < 21'h800) begin
         add_byte({3'b110, cp[10:6]});
         add_byte({2'b10, cp[5:0]});
      end else if (cp < 21'h10000) begin
         add_byte({4'b1110, cp[15:12]});
         add_byte({2'b10, cp[11:6]});
         add_byte({2'b10, cp[5:0]});
      end else begin
         add_byte({5'b11110, cp[20:18]});
         add_byte({2'b10, cp[17:12]});
         add_byte({2'b10, cp[11:6]});
         add_byte({2'b10, cp[5:0]});
      end
   endfunction

   // malformed sequences: bad leads and out-of-range continuations
   function automatic void put_broken();
      case ($urandom_range(0, 5))
         0: add_byte($urandom_range(0, 1) ? 8'($urandom_range(8'h80, 8'hC1)) :
                                            8'($urandom_range(8'hF5, 8'hFF)));
         1: stream_q = {stream_q, 8'hE0, 8'($urandom_range(8'h80, 8'h9F))};
         2: stream_q = {stream_q, 8'hED, 8'($urandom_range(8'hA0, 8'hBF))};
         3: stream_q = {stream_q, 8'hF0, 8'($urandom_range(8'h80, 8'h8F))};
         4: stream_q = {stream_q, 8'hF4, 8'($urandom_range(8'h90, 8'hBF))};
         default: begin
            add_byte(8'($urandom_range(8'hC2, 8'hF4)));
            add_byte($urandom_range(0, 1) ? 8'($urandom_range(8'h00, 8'h7F)) :
                                            8'($urandom_range(8'hC0, 8'hFF)));
         end
      endcase
   endfunction

   function automatic void build_stream();
      int points;
      int r;
      int start_len;
      int len;
      stream_q.delete();
      points = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 6);
      repeat (points) begin
         r = $urandom_range(0, 99);
         if (r < 94) put_point(random_point());
         else if (r < 98) put_broken();
         else add_byte(8'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 9) == 0) begin
         start_len = stream_q.size();
         put_point(random_point());
         len = stream_q.size() - start_len;
         if (len > 1) repeat ($urandom_range(1, len - 1)) void'(stream_q.pop_back());
      end
   endfunction

   task automatic send_byte(input logic [7:0] b, input logic fin, input bit calm);
      int gap;
      gap = calm ? 0 : pick_gap();
      repeat (gap) begin
         @(negedge clock);
         req_valid = 1'b0;
      end
      @(negedge clock);
      req_valid      = 1'b1;
      req_data_byte  = b;
      req_final_byte = fin;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic send_stream(input bit calm);
      for (int i = 0; i < stream_q.size(); i++)
         send_byte(stream_q[i], i == stream_q.size() - 1, calm);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // range extremes of the one-, three- and four-byte sequence lengths
      stream_q = {8'h7F, 8'hE0, 8'hA0, 8'h80, 8'hF4, 8'h8F, 8'hBF, 8'hBF};
      send_stream(1'b0);
      // earlier point kept, invalid lead, bytes ignored after the error
      stream_q = {8'h00, 8'hED, 8'h9F, 8'hBF, 8'h80, 8'h41, 8'hFF};
      send_stream(1'b0);
      // bad continuation after a four-byte lead
      stream_q = {8'hF0, 8'h8F};
      send_stream(1'b1);
      // stream ends mid-sequence
      stream_q = {8'hE3, 8'h80};
      send_stream(1'b0);
      stream_q = {8'hF5};
      send_stream(1'b0);
      stream_q = {8'hC2, 8'hA0, 8'h20};
      send_stream(1'b1);

      while (sb.noted_bytes < ITEM_GOAL) begin
         build_stream();
         send_stream($urandom_range(0, 4) == 0);
      end
      @(negedge clock);
      req_valid = 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

@@ utf8_validating_decoder.f @@
+incdir+hdl
hdl/utf8vd_pkg.sv
hdl/utf8vd_step.sv
hdl/utf8_validating_decoder.sv
hdl/utf8vd_checker.sv
verif/utf8vd_check_pkg.sv
verif/tb_top.sv
